// ----- rtl/core/ied_pkg.sv -----
package ied_pkg;

  // Parser states of the escape sequence tracker
  typedef enum logic [2:0] {
    PS_NONE   = 3'd0,
    PS_ESC    = 3'd1,
    PS_SECOND = 3'd2,
    PS_THIRD  = 3'd3,
    PS_ASCII  = 3'd4,
    PS_OTHER  = 3'd5
  } parse_state_t;

  // Intermediate byte seen after ESC
  typedef enum logic [1:0] {
    INTRO_NONE   = 2'd0,
    INTRO_PAREN  = 2'd1,
    INTRO_DOLLAR = 2'd2,
    INTRO_DOT    = 2'd3
  } intro_kind_t;

  // Detected label and reported verdict share one code space
  typedef enum logic [1:0] {
    VERDICT_GENERIC = 2'd0,
    VERDICT_JP      = 2'd1,
    VERDICT_CN      = 2'd2,
    VERDICT_UNKNOWN = 2'd3
  } verdict_t;

  // Occupancy flags of the front-to-back queue
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ESC    = 8'h1B;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_B      = 8'h42;

  localparam int TOL_BITS  = 16;
  localparam int OUT_BITS  = 32;
  localparam int QUEUE_DEPTH = 4;

endpackage

// ----- rtl/core/ied_front.sv -----
module ied_front import ied_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  output logic                      q_push,
  output logic [2*COUNT_BITS+1:0]   q_data
);

  parse_state_t            state, state_next, eff_state;
  intro_kind_t             intro, intro_next;
  verdict_t                label, label_next;
  logic [COUNT_BITS-1:0]   good_cnt, bad_cnt;
  logic [COUNT_BITS-1:0]   good_sat, bad_sat;
  logic [COUNT_BITS:0]     good_sum, bad_sum;
  logic [1:0]              good_inc;
  logic                    bad_inc;

  // A newline restarts the parser before the byte is judged
  assign eff_state = (data_byte == CHAR_LF) ? PS_NONE : state;

  // Next state, intermediate and label
  always_comb begin
    state_next = eff_state;
    intro_next = intro;
    label_next = label;
    unique case (eff_state)
      PS_NONE: begin
        if (data_byte == CHAR_ESC) state_next = PS_ESC;
      end
      PS_ESC: begin
        if (data_byte == CHAR_LPAREN) begin
          intro_next = INTRO_PAREN;
          state_next = PS_SECOND;
        end else if (data_byte == CHAR_DOLLAR) begin
          intro_next = INTRO_DOLLAR;
          state_next = PS_SECOND;
        end else if (data_byte == CHAR_DOT) begin
          intro_next = INTRO_DOT;
          state_next = PS_SECOND;
        end
      end
      PS_SECOND: begin
        case (data_byte) inside
          "B", "J", "@", "(", "A", "F", "I": begin
            if (intro == INTRO_PAREN && data_byte == CHAR_B) state_next = PS_ASCII;
            else if (intro == INTRO_DOLLAR && data_byte == CHAR_LPAREN) state_next = PS_THIRD;
            else state_next = PS_OTHER;
          end
          default: state_next = PS_SECOND;
        endcase
      end
      PS_THIRD: begin
        case (data_byte) inside
          "D", "O", "P", "Q": begin
            label_next = VERDICT_JP;
            state_next = PS_OTHER;
          end
          "C": begin
            if (label != VERDICT_JP) begin
              label_next = VERDICT_JP;
              state_next = PS_OTHER;
            end else begin
              state_next = PS_NONE;
            end
          end
          "A", "G", "H", "E", "I", "J", "K", "L", "M": begin
            label_next = VERDICT_CN;
            state_next = PS_OTHER;
          end
          default: state_next = PS_NONE;
        endcase
      end
      PS_ASCII: state_next = PS_ASCII;
      PS_OTHER: begin
        if (data_byte == CHAR_ESC) state_next = PS_ESC;
      end
      default: state_next = eff_state;
    endcase
  end

  // Counter increments for this byte
  always_comb begin
    good_inc = 2'd0;
    bad_inc  = 1'b0;
    unique case (eff_state)
      PS_NONE: begin
        if (data_byte == CHAR_ESC) good_inc = 2'd1;
        else if (data_byte[7]) bad_inc = 1'b1;
      end
      PS_ESC: begin
        if (data_byte == CHAR_LPAREN || data_byte == CHAR_DOLLAR || data_byte == CHAR_DOT)
          good_inc = 2'd1;
        else
          bad_inc = 1'b1;
      end
      PS_SECOND: begin
        case (data_byte) inside
          "B", "J", "@", "(", "A", "F", "I": good_inc = 2'd1;
          default: bad_inc = 1'b1;
        endcase
      end
      PS_THIRD: begin
        case (data_byte) inside
          "D", "O", "P", "Q", "A", "G", "H", "E", "I", "J", "K", "L", "M":
            good_inc = 2'd1;
          "C": begin
            if (label != VERDICT_JP) good_inc = 2'd1;
            else bad_inc = 1'b1;
          end
          default: bad_inc = 1'b1;
        endcase
      end
      PS_ASCII: begin
        if (data_byte[7]) bad_inc = 1'b1;
        else good_inc = 2'd1;
      end
      PS_OTHER: begin
        // ESC here counts for the closed run and the new sequence
        good_inc = (data_byte == CHAR_ESC) ? 2'd2 : 2'd1;
      end
      default: begin
        good_inc = 2'd0;
        bad_inc  = 1'b0;
      end
    endcase
  end

  // Saturating counters: the carry bit flags a pass beyond the top
  assign good_sum = {1'b0, good_cnt} + (COUNT_BITS+1)'(good_inc);
  assign bad_sum  = {1'b0, bad_cnt} + (COUNT_BITS+1)'(bad_inc);
  assign good_sat = good_sum[COUNT_BITS] ? '1 : good_sum[COUNT_BITS-1:0];
  assign bad_sat  = bad_sum[COUNT_BITS] ? '1 : bad_sum[COUNT_BITS-1:0];

  // Hand the finished text to the back on its last beat
  assign q_push = accept && last_byte;
  assign q_data = {label_next, good_sat, bad_sat};

  // Advance parser state; clear it after the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= PS_NONE;
      intro    <= INTRO_NONE;
      label    <= VERDICT_GENERIC;
      good_cnt <= '0;
      bad_cnt  <= '0;
    end else if (accept) begin
      if (last_byte) begin
        state    <= PS_NONE;
        intro    <= INTRO_NONE;
        label    <= VERDICT_GENERIC;
        good_cnt <= '0;
        bad_cnt  <= '0;
      end else begin
        state    <= state_next;
        intro    <= intro_next;
        label    <= label_next;
        good_cnt <= good_sat;
        bad_cnt  <= bad_sat;
      end
    end
  end

endmodule

// ----- rtl/core/ied_queue.sv -----
module ied_queue import ied_pkg::*; #(
  parameter int WIDTH = 66
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output queue_status_t      status
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0]    slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [PTR_BITS:0]   level;

  assign status.full  = (level == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign status.empty = (level == '0);
  assign rdata        = slots[rd_ptr];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

// ----- rtl/core/ied_back.sv -----
module ied_back import ied_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [TOL_BITS-1:0]       tolerance,
  input  logic [2*COUNT_BITS+1:0]   q_data,
  input  queue_status_t             q_status,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [1:0]                verdict,
  output logic [OUT_BITS-1:0]       correct_total,
  output logic [OUT_BITS-1:0]       error_total
);

  localparam int PROD_BITS = COUNT_BITS + 1 + TOL_BITS;

  logic                    advance;
  verdict_t                q_label;
  logic [COUNT_BITS-1:0]   q_good, q_bad;

  logic                    s1_valid;
  verdict_t                s1_label;
  logic [COUNT_BITS-1:0]   s1_good, s1_bad;
  logic [COUNT_BITS:0]     s1_total;

  logic                    s2_valid;
  verdict_t                s2_label;
  logic [COUNT_BITS-1:0]   s2_good, s2_bad;
  logic [PROD_BITS-1:0]    s2_lhs, s2_rhs;

  logic                    out_valid;
  logic [OUT_BITS-1:0]     good_clip, bad_clip;

  assign q_label = verdict_t'(q_data[2*COUNT_BITS+1:2*COUNT_BITS]);
  assign q_good  = q_data[2*COUNT_BITS-1:COUNT_BITS];
  assign q_bad   = q_data[COUNT_BITS-1:0];

  // The whole pipe moves while the output slot is free or being taken
  assign advance = !out_valid || pop;
  assign q_pop   = advance && !q_status.empty;
  assign empty   = !out_valid;

  // Clip wide counts to the 32-bit result fields
  if (COUNT_BITS > OUT_BITS) begin : g_clip
    assign good_clip = (|s2_good[COUNT_BITS-1:OUT_BITS]) ? '1 : s2_good[OUT_BITS-1:0];
    assign bad_clip  = (|s2_bad[COUNT_BITS-1:OUT_BITS]) ? '1 : s2_bad[OUT_BITS-1:0];
  end else begin : g_pad
    assign good_clip = OUT_BITS'(s2_good);
    assign bad_clip  = OUT_BITS'(s2_bad);
  end

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !q_status.empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Stage 1: total of counted bytes
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_label <= q_label;
      s1_good  <= q_good;
      s1_bad   <= q_bad;
      s1_total <= {1'b0, q_good} + {1'b0, q_bad};
    end
  end

  // Stage 2: errors scaled by 2^16 against total times tolerance
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_label <= s1_label;
      s2_good  <= s1_good;
      s2_bad   <= s1_bad;
      s2_lhs   <= {1'b0, s1_bad, {TOL_BITS{1'b0}}};
      s2_rhs   <= PROD_BITS'(s1_total) * PROD_BITS'(tolerance);
    end
  end

  // Stage 3: compare and hold the result beat
  always_ff @(posedge clk) begin
    if (advance) begin
      verdict       <= (s2_lhs <= s2_rhs) ? s2_label : VERDICT_UNKNOWN;
      correct_total <= good_clip;
      error_total   <= bad_clip;
    end
  end

endmodule

// ----- rtl/core/iso2022_escape_detector_core.sv -----
// Channel   | Handshake        | Ports
// ----------+------------------+---------------------------------------------
// input     | push / full      | data_byte[7:0], last_byte
// result    | pop / empty      | verdict[1:0], correct_total[31:0], error_total[31:0]
// config    | tolerance_we     | tolerance_wdata[15:0]
//
// One byte is accepted per cycle while full is low; the parser updates in the
// cycle a beat is taken. A last byte passes the queue and three verdict stages
// (add, multiply, compare) to the outputs, one verdict per cycle when pop is held.
// Reset clears parser, queue and pipe; tolerance resets to zero.
// A held result stalls the verdict pipe; full rises once four verdicts wait in
// the queue behind it, and then every byte waits until the pipe moves again.
module iso2022_escape_detector_core import ied_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic                  pop,
  output logic                  empty,
  output logic [1:0]            verdict,
  output logic [OUT_BITS-1:0]   correct_total,
  output logic [OUT_BITS-1:0]   error_total,
  input  logic                  tolerance_we,
  input  logic [TOL_BITS-1:0]   tolerance_wdata
);

  localparam int ENTRY_BITS = 2*COUNT_BITS + 2;

  logic                    accept;
  logic                    q_push, q_pop;
  logic [ENTRY_BITS-1:0]   q_wdata, q_rdata;
  queue_status_t           q_status;
  logic [TOL_BITS-1:0]     tolerance;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  // Hold the tolerance register
  always_ff @(posedge clk) begin
    if (rst) tolerance <= '0;
    else if (tolerance_we) tolerance <= tolerance_wdata;
  end

  ied_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  ied_queue #(.WIDTH(ENTRY_BITS)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  ied_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .tolerance     (tolerance),
    .q_data        (q_rdata),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .verdict       (verdict),
    .correct_total (correct_total),
    .error_total   (error_total)
  );

  // Front never writes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue written while full");

  // Back never reads an empty queue
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");

  // Queue flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  // A last beat always lands in the queue
  a_last_push: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> !q_status.empty)
    else $error("last beat not queued");

endmodule
